FILE: sv/tms_pkg.sv
package tms_pkg;

    // command codes
    localparam logic [2:0] CMD_LOAD_MAP  = 3'd0;
    localparam logic [2:0] CMD_LOAD_TILE = 3'd1;
    localparam logic [2:0] CMD_DRAW      = 3'd2;
    localparam logic [2:0] CMD_COLLIDE   = 3'd3;
    localparam logic [2:0] CMD_READ_LINE = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_TILE_SIZE   = 3'd2;
    localparam logic [2:0] REG_TRANSPARENT = 3'd3;
    localparam logic [2:0] REG_VIS_WIDTH   = 3'd4;

    // reply kinds
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_HIT  = 1'b1;

    // tile edges
    localparam logic [4:0] TS_SMALL = 5'd8;
    localparam logic [4:0] TS_BIG   = 5'd16;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [6:0] map_width;
        logic [6:0] map_height;
        logic       tile_size_sel;
        logic       transparent_mode;
        logic [9:0] visible_width;
    } cfg_t;

    // one classified command
    typedef struct packed {
        logic [2:0]         cmd;
        logic [14:0]        mem_addr;
        logic [31:0]        load_data;
        logic               go;
        logic [6:0]         rsel;
        logic [3:0]         sub;
        logic [7:0]         first_col;
        logic signed [12:0] dst;
        logic [7:0]         frame;
        logic [6:0]         x1;
        logic [6:0]         x2;
        logic [6:0]         y2;
    } job_t;

endpackage

FILE: sv/tms_if.sv
interface tms_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [14:0]        mem_addr;
    logic [31:0]        load_data;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [9:0]         scan_line;
    logic [7:0]         frame_num;
    logic signed [10:0] box_x;
    logic signed [10:0] box_y;
    logic [9:0]         box_w;
    logic [9:0]         box_h;

    modport source (output valid, cmd, mem_addr, load_data, pos_x, pos_y, scan_line,
                    frame_num, box_x, box_y, box_w, box_h, input ready);
    modport sink (input valid, cmd, mem_addr, load_data, pos_x, pos_y, scan_line,
                  frame_num, box_x, box_y, box_w, box_h, output ready);
endinterface

interface tms_out_if;
    logic        valid;
    logic        ready;
    logic        reply_kind;
    logic [31:0] line_word;
    logic        hit_flag;

    modport source (output valid, reply_kind, line_word, hit_flag, input ready);
    modport sink (input valid, reply_kind, line_word, hit_flag, output ready);
endinterface

interface tms_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/tms_queue.sv
module tms_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tms_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output tms_pkg::job_t head_job,
    output logic          head_valid
);
    localparam int PW = $clog2(tms_pkg::QUEUE_DEPTH);

    tms_pkg::job_t   slot_reg [tms_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full       = (cnt_reg == (PW+1)'(tms_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end
endmodule

FILE: sv/tms_front.sv
module tms_front
#(
    parameter int MARGIN = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    tms_in_if.sink        cmd_ch,
    tms_cfg_if.sink       cfg_ch,
    input  logic          queue_full,
    input  logic          clear_done,
    output logic          push,
    output tms_pkg::job_t push_job,
    output tms_pkg::cfg_t cfg
);
    tms_pkg::cfg_t cfg_reg, cfg_next;

    logic signed [10:0] x_e;
    logic signed [11:0] sprline;
    logic [10:0]        span;
    logic [10:0]        nx;
    logic [7:0]         st;
    logic [12:0]        st_px;
    logic signed [12:0] v_x1, v_x2, v_y1, v_y2;
    logic [6:0]         cx1, cx2, cy1, cy2;
    logic               sel;

    // truncating divide by tile edge, clamped to [0, lim]
    function automatic logic [6:0] tile_clamp(input logic signed [12:0] v,
                                              input logic s, input logic [6:0] lim);
        logic [8:0] q;
        begin
            q = s ? {1'b0, v[11:4]} : v[11:3];
            if (v[12])
                tile_clamp = '0;
            else if (q > {2'b00, lim})
                tile_clamp = lim;
            else
                tile_clamp = q[6:0];
        end
    endfunction

    assign sel = cfg_reg.tile_size_sel;
    assign cfg = cfg_reg;
    assign cfg_ch.ready = 1'b1;
    assign cmd_ch.ready = !queue_full && clear_done;
    assign push = cmd_ch.valid && cmd_ch.ready && (cmd_ch.cmd <= tms_pkg::CMD_READ_LINE);

    always_comb
    begin
        x_e     = {cmd_ch.pos_x[10:1], 1'b0};
        sprline = $signed({2'b00, cmd_ch.scan_line}) - 12'(cmd_ch.pos_y);
        span    = sel ? {cfg_reg.map_height, 4'b0} : {1'b0, cfg_reg.map_height, 3'b0};
        nx      = x_e[10] ? 11'd0 - x_e : 11'd0;
        st      = sel ? {1'b0, nx[10:4]} : nx[10:3];
        st_px   = sel ? {1'b0, st, 4'b0} : {2'b00, st, 3'b0};
        v_x1    = 13'(cmd_ch.box_x) - 13'(x_e);
        v_x2    = 13'(cmd_ch.box_x) + 13'(cmd_ch.box_w) - 13'(x_e);
        v_y1    = 13'(cmd_ch.box_y) - 13'(cmd_ch.pos_y);
        v_y2    = 13'(cmd_ch.box_y) + 13'(cmd_ch.box_h) - 13'(cmd_ch.pos_y);
        cx1     = tile_clamp(v_x1, sel, cfg_reg.map_width);
        cx2     = tile_clamp(v_x2, sel, cfg_reg.map_width);
        cy1     = tile_clamp(v_y1, sel, cfg_reg.map_height);
        cy2     = tile_clamp(v_y2, sel, cfg_reg.map_height);

        push_job.cmd       = cmd_ch.cmd;
        push_job.mem_addr  = cmd_ch.mem_addr;
        push_job.load_data = cmd_ch.load_data;
        push_job.sub       = sel ? sprline[3:0] : {1'b0, sprline[2:0]};
        push_job.first_col = st;
        push_job.dst       = 13'(x_e) + 13'(MARGIN) + st_px;
        push_job.frame     = cmd_ch.frame_num;
        push_job.x1        = cx1;
        push_job.x2        = cx2;
        push_job.y2        = cy2;
        if (cmd_ch.cmd == tms_pkg::CMD_COLLIDE)
        begin
            push_job.go   = (cx1 < cx2) && (cy1 < cy2);
            push_job.rsel = cy1;
        end
        else
        begin
            push_job.go   = !sprline[11] && (sprline[10:0] < span);
            push_job.rsel = sel ? sprline[10:4] : sprline[9:3];
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                tms_pkg::REG_MAP_WIDTH:   cfg_next.map_width = cfg_ch.data[6:0];
                tms_pkg::REG_MAP_HEIGHT:  cfg_next.map_height = cfg_ch.data[6:0];
                tms_pkg::REG_TILE_SIZE:   cfg_next.tile_size_sel = cfg_ch.data[0];
                tms_pkg::REG_TRANSPARENT: cfg_next.transparent_mode = cfg_ch.data[0];
                tms_pkg::REG_VIS_WIDTH:   cfg_next.visible_width = cfg_ch.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width        <= 7'd1;
            cfg_reg.map_height       <= 7'd1;
            cfg_reg.tile_size_sel    <= 1'b1;
            cfg_reg.transparent_mode <= 1'b1;
            cfg_reg.visible_width    <= 10'd640;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

FILE: sv/tms_back.sv
module tms_back
#(
    parameter int MAP_ENTRIES     = 4096,
    parameter int NUM_TILES       = 256,
    parameter int TILE_SLOT_WORDS = 128,
    parameter int LINE_WORDS      = 512,
    parameter int MARGIN          = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tms_pkg::cfg_t cfg,
    input  tms_pkg::job_t head_job,
    input  logic          head_valid,
    output logic          pop,
    output logic          clear_done,
    tms_out_if.source     rsp_ch
);
    localparam int TILE_WORDS = NUM_TILES * TILE_SLOT_WORDS;
    localparam int MAW = $clog2(MAP_ENTRIES);
    localparam int TAW = $clog2(TILE_WORDS);
    localparam int LAW = $clog2(LINE_WORDS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SET1  = 4'd2;
    localparam logic [3:0] S_SET2  = 4'd3;
    localparam logic [3:0] S_DMAP  = 4'd4;
    localparam logic [3:0] S_DMAPW = 4'd5;
    localparam logic [3:0] S_DPIX  = 4'd6;
    localparam logic [3:0] S_DNEXT = 4'd7;
    localparam logic [3:0] S_CMAP  = 4'd8;
    localparam logic [3:0] S_CMAPW = 4'd9;
    localparam logic [3:0] S_RREAD = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [7:0]  map_mem  [MAP_ENTRIES];
    logic [31:0] tile_mem [TILE_WORDS];
    logic [31:0] line_mem [LINE_WORDS];

    logic [3:0]         state_reg, state_next;
    tms_pkg::job_t      job_reg, job_next;
    logic [7:0]         i_reg, i_next;
    logic [6:0]         r_reg, r_next;
    logic [15:0]        t_reg, t_next;
    logic [23:0]        rowaddr_reg, rowaddr_next;
    logic signed [12:0] dst_reg, dst_next;
    logic [2:0]         j_reg, j_next;
    logic [7:0]         idx_reg, idx_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [12:0]        wr_p_reg, wr_p_next;
    logic [LAW-1:0]     clr_reg, clr_next;
    logic               kind_reg, kind_next;
    logic               hit_reg, hit_next;
    logic               ovalid_reg, ovalid_next;
    logic               okind_reg, okind_next;
    logic [31:0]        oword_reg, oword_next;
    logic               ohit_reg, ohit_next;

    logic [7:0]         map_q;
    logic [31:0]        tile_q;
    logic [31:0]        line_q;
    logic [MAW-1:0]     map_raddr;
    logic [TAW-1:0]     tile_raddr;
    logic [31:0]        tile_lin;
    logic [6:0]         offset;
    logic [2:0]         j_last;
    logic [12:0]        limit;
    logic               lb_we;
    logic [LAW-1:0]     lb_waddr;
    logic [31:0]        lb_wdata;
    logic               wr_ok;
    logic               map_we, tile_we, line_re;
    logic               slot_free;

    assign clear_done = (state_reg != S_CLEAR);
    assign slot_free  = !ovalid_reg || rsp_ch.ready;

    assign rsp_ch.valid      = ovalid_reg;
    assign rsp_ch.reply_kind = okind_reg;
    assign rsp_ch.line_word  = oword_reg;
    assign rsp_ch.hit_flag   = ohit_reg;

    always_comb
    begin
        offset   = cfg.tile_size_sel ? {job_reg.sub, 3'b0}
                                     : {2'b00, job_reg.sub[2:0], 2'b0};
        j_last   = cfg.tile_size_sel ? 3'd7 : 3'd3;
        limit    = 13'(cfg.visible_width) + 13'(MARGIN);
        map_raddr  = MAW'(rowaddr_reg + 24'(i_reg));
        tile_lin   = 32'(idx_reg) * 32'(TILE_SLOT_WORDS) + 32'(offset) + 32'(j_reg);
        tile_raddr = tile_lin[TAW-1:0];

        // pending pixel pair write, in the cycle after the tile read
        wr_ok = wr_pend_reg && !wr_p_reg[12]
                && ({1'b0, wr_p_reg[12:1]} < 13'(LINE_WORDS))
                && !(cfg.transparent_mode && (tile_q == '0));
        if (state_reg == S_CLEAR)
        begin
            lb_we    = 1'b1;
            lb_waddr = clr_reg;
            lb_wdata = '0;
        end
        else
        begin
            lb_we    = wr_ok;
            lb_waddr = wr_p_reg[LAW:1];
            lb_wdata = tile_q;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        i_next       = i_reg;
        r_next       = r_reg;
        t_next       = t_reg;
        rowaddr_next = rowaddr_reg;
        dst_next     = dst_reg;
        j_next       = j_reg;
        idx_next     = idx_reg;
        wr_pend_next = 1'b0;
        wr_p_next    = wr_p_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        hit_next     = hit_reg;
        ovalid_next  = ovalid_reg && !rsp_ch.ready;
        okind_next   = okind_reg;
        oword_next   = oword_reg;
        ohit_next    = ohit_reg;
        pop          = 1'b0;
        map_we       = 1'b0;
        tile_we      = 1'b0;
        line_re      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAW'(LINE_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    job_next = head_job;
                    unique case (head_job.cmd)
                        tms_pkg::CMD_LOAD_MAP:  map_we = 1'b1;
                        tms_pkg::CMD_LOAD_TILE: tile_we = 1'b1;
                        tms_pkg::CMD_DRAW:
                        begin
                            if (head_job.go)
                                state_next = S_SET1;
                        end
                        tms_pkg::CMD_COLLIDE:
                        begin
                            kind_next = tms_pkg::KIND_HIT;
                            hit_next  = 1'b0;
                            state_next = head_job.go ? S_SET1 : S_OUT;
                        end
                        tms_pkg::CMD_READ_LINE:
                        begin
                            kind_next  = tms_pkg::KIND_LINE;
                            state_next = S_RREAD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SET1:
            begin
                t_next   = 16'(job_reg.frame * cfg.map_height) + 16'(job_reg.rsel);
                r_next   = job_reg.rsel;
                dst_next = job_reg.dst;
                i_next   = (job_reg.cmd == tms_pkg::CMD_DRAW) ? job_reg.first_col
                                                             : {1'b0, job_reg.x1};
                state_next = S_SET2;
            end
            S_SET2:
            begin
                rowaddr_next = 24'(t_reg * cfg.map_width);
                state_next   = (job_reg.cmd == tms_pkg::CMD_DRAW) ? S_DMAP : S_CMAP;
            end
            S_DMAP:
            begin
                if ((i_reg < {1'b0, cfg.map_width}) && (dst_reg < $signed(limit)))
                    state_next = S_DMAPW;
                else
                    state_next = S_IDLE;
            end
            S_DMAPW:
            begin
                idx_next   = map_q;
                j_next     = '0;
                state_next = (map_q != '0) ? S_DPIX : S_DNEXT;
            end
            S_DPIX:
            begin
                wr_pend_next = 1'b1;
                wr_p_next    = dst_reg + 13'({j_reg, 1'b0});
                j_next       = j_reg + 1'b1;
                if (j_reg == j_last)
                    state_next = S_DNEXT;
            end
            S_DNEXT:
            begin
                i_next     = i_reg + 1'b1;
                dst_next   = dst_reg + 13'(cfg.tile_size_sel ? tms_pkg::TS_BIG
                                                            : tms_pkg::TS_SMALL);
                state_next = S_DMAP;
            end
            S_CMAP:
            begin
                state_next = S_CMAPW;
            end
            S_CMAPW:
            begin
                if (map_q != '0)
                begin
                    hit_next   = 1'b1;
                    state_next = S_OUT;
                end
                else if ((i_reg + 1'b1) < {1'b0, job_reg.x2})
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CMAP;
                end
                else if (({1'b0, r_reg} + 1'b1) < {1'b0, job_reg.y2})
                begin
                    r_next       = r_reg + 1'b1;
                    i_next       = {1'b0, job_reg.x1};
                    rowaddr_next = rowaddr_reg + 24'(cfg.map_width);
                    state_next   = S_CMAP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RREAD:
            begin
                line_re    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = kind_reg;
                    oword_next  = (kind_reg == tms_pkg::KIND_LINE) ? line_q : '0;
                    ohit_next   = (kind_reg == tms_pkg::KIND_HIT) ? hit_reg : 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            wr_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wr_pend_reg <= wr_pend_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        i_reg       <= i_next;
        r_reg       <= r_next;
        t_reg       <= t_next;
        rowaddr_reg <= rowaddr_next;
        dst_reg     <= dst_next;
        j_reg       <= j_next;
        idx_reg     <= idx_next;
        wr_p_reg    <= wr_p_next;
        kind_reg    <= kind_next;
        hit_reg     <= hit_next;
        okind_reg   <= okind_next;
        oword_reg   <= oword_next;
        ohit_reg    <= ohit_next;
    end

    // tilemap memory
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[MAW'(head_job.mem_addr)] <= head_job.load_data[7:0];
        map_q <= map_mem[map_raddr];
    end

    // tile pixel memory
    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[TAW'(head_job.mem_addr)] <= head_job.load_data;
        tile_q <= tile_mem[tile_raddr];
    end

    // line buffer
    always_ff @(posedge clk)
    begin
        if (lb_we)
            line_mem[lb_waddr] <= lb_wdata;
        if (line_re)
            line_q <= line_mem[job_reg.mem_addr[LAW-1:0]];
    end
endmodule

FILE: sv/tilemap_sprite_line_blitter_unit.sv
// sequence: a load is written when popped, a line read is a buffer read and then the reply,
// a collide tests box cells until a hit, a draw reads the row's map cells and drawn tile words
// throughput: one command at a time in the back end, set by its map and tile memory port walk
// a two-entry queue lets commands be taken while the back end is busy or a reply waits
// reset: control cleared, registers to defaults, then a clearing pass zeroes every word of the
// line buffer; no command transaction is taken until it ends, config is taken
module tilemap_sprite_line_blitter_unit
#(
    parameter int MAP_ENTRIES     = 4096,
    parameter int NUM_TILES       = 256,
    parameter int TILE_SLOT_WORDS = 128,
    parameter int LINE_WORDS      = 512,
    parameter int MARGIN          = 16
)
(
    input logic       clk,
    input logic       rst_n,
    tms_in_if.sink    cmd_ch,
    tms_out_if.source rsp_ch,
    tms_cfg_if.sink   cfg_ch
);
    // front to queue
    tms_pkg::job_t push_job;
    logic          push;
    logic          queue_full;

    // queue to back end
    tms_pkg::job_t head_job;
    logic          head_valid;
    logic          pop;

    // shared settings and clearing status
    tms_pkg::cfg_t cfg;
    logic          clear_done;

    // front: takes command and config transactions, precomputes clip and box ranges
    tms_front
    #(
        .MARGIN (MARGIN)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .cfg_ch     (cfg_ch),
        .queue_full (queue_full),
        .clear_done (clear_done),
        .push       (push),
        .push_job   (push_job),
        .cfg        (cfg)
    );

    // short queue decoupling the two sides
    tms_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    // back end: memories, draw and collide sequencer, reply register
    tms_back
    #(
        .MAP_ENTRIES     (MAP_ENTRIES),
        .NUM_TILES       (NUM_TILES),
        .TILE_SLOT_WORDS (TILE_SLOT_WORDS),
        .LINE_WORDS      (LINE_WORDS),
        .MARGIN          (MARGIN)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .clear_done (clear_done),
        .rsp_ch     (rsp_ch)
    );
endmodule

FILE: sv/tms_checker.sv
module tms_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        reply_kind,
    input logic [31:0] line_word,
    input logic        hit_flag
);
    // reply held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_word) && $stable(hit_flag))
        else $error("reply changed before taken");

    // clearing pass keeps commands out right after reset
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !cmd_ready && !rsp_valid)
        else $error("command taken during clearing pass");

    // unused reply fields read zero
    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (reply_kind ? (line_word == 32'd0) : !hit_flag))
        else $error("reply field not zero");

    a_rsp_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(rsp_ready))
        else $error("reply dropped");
endmodule

bind tilemap_sprite_line_blitter_unit tms_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd_ch.ready),
    .rsp_valid  (rsp_ch.valid),
    .rsp_ready  (rsp_ch.ready),
    .reply_kind (rsp_ch.reply_kind),
    .line_word  (rsp_ch.line_word),
    .hit_flag   (rsp_ch.hit_flag)
);

FILE: verif/tb_tilemap_sprite_line_blitter_unit.sv
`timescale 1ns / 1ps

module tb_tilemap_sprite_line_blitter_unit;

    localparam int MAP_ENTRIES     = 4096;
    localparam int NUM_TILES       = 256;
    localparam int TILE_SLOT_WORDS = 128;
    localparam int LINE_WORDS      = 512;
    localparam int MARGIN          = 16;
    localparam int TILE_WORDS      = NUM_TILES * TILE_SLOT_WORDS;

    // preloaded region: map entries below MAP_LOADED, tile slots 1 and 2
    localparam int MAP_LOADED      = 256;
    localparam int TILE_FIRST_WORD = TILE_SLOT_WORDS;
    localparam int TILE_LOADED     = 2 * TILE_SLOT_WORDS;
    localparam int TOP_TILE_INDEX  = 2;

    // one command transaction as the sender drives it
    typedef struct {
        logic [2:0]         cmd;
        logic [14:0]        mem_addr;
        logic [31:0]        load_data;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic [9:0]         scan_line;
        logic [7:0]         frame_num;
        logic signed [10:0] box_x;
        logic signed [10:0] box_y;
        logic [9:0]         box_w;
        logic [9:0]         box_h;
    } blit_cmd_t;

    typedef struct {
        logic        reply_kind;
        logic [31:0] line_word;
        logic        hit_flag;
    } blit_reply_t;

    logic clk;
    logic rst_n;

    tms_in_if  cmd_if();
    tms_out_if rsp_if();
    tms_cfg_if cfg_if();

    tilemap_sprite_line_blitter_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_if),
        .rsp_ch (rsp_if),
        .cfg_ch (cfg_if)
    );

    // shadow copy of the block's memories and registers
    logic [7:0]  shadow_map [MAP_ENTRIES];
    logic [31:0] shadow_tile [TILE_WORDS];
    logic [31:0] shadow_line [LINE_WORDS];
    int          sh_map_width;
    int          sh_map_height;
    int          sh_tile_big;
    int          sh_transparent;
    int          sh_vis_width;
    int          frame_top;

    blit_reply_t pending_replies [$];
    int          error_count;
    int          src_idle_pct;
    int          sink_idle_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stalls, re-rolled every falling edge
    always @(negedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // generous limit on the whole run
    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int clip(int v, int lo, int hi);
        return v > lo ? (v < hi ? v : hi) : lo;
    endfunction

    // render one sprite row into the shadow line buffer
    function automatic void render_row(blit_cmd_t c);
        int ts;
        int x;
        int sprline;
        int first_col;
        int row_base;
        int offset;
        int dst;
        int limit;
        int src;
        int p;
        logic [7:0]  idx;
        logic [31:0] pair;
        ts      = sh_tile_big ? 16 : 8;
        x       = int'(c.pos_x) & ~1;
        sprline = int'(c.scan_line) - int'(c.pos_y);
        if (sprline < 0 || sprline >= ts * sh_map_height)
            return;
        first_col = (x < 0 ? -x : 0) / ts;
        row_base  = (int'(c.frame_num) * sh_map_height + sprline / ts) * sh_map_width;
        offset    = (sprline % ts) * (ts / 2);
        dst       = x + MARGIN + first_col * ts;
        limit     = sh_vis_width + MARGIN;
        for (int i = first_col; i < sh_map_width && dst < limit; i++)
        begin
            idx = shadow_map[(row_base + i) % MAP_ENTRIES];
            if (idx != 0)
            begin
                src = int'(idx) * TILE_SLOT_WORDS + offset;
                for (int j = 0; j < ts / 2; j++)
                begin
                    pair = shadow_tile[(src + j) % TILE_WORDS];
                    p    = dst + 2 * j;
                    // transparent mode leaves zero pairs alone
                    if (!(sh_transparent && pair == 0) && p >= 0 && (p >> 1) < LINE_WORDS)
                        shadow_line[p >> 1] = pair;
                end
            end
            dst += ts;
        end
    endfunction

    // does any nonzero map cell of the frame fall inside the box
    function automatic logic box_hits_tile(blit_cmd_t c);
        int ts;
        int sx;
        int sy;
        int x1;
        int x2;
        int y1;
        int y2;
        int base;
        ts   = sh_tile_big ? 16 : 8;
        sx   = int'(c.pos_x) & ~1;
        sy   = int'(c.pos_y);
        x1   = clip((int'(c.box_x) - sx) / ts, 0, sh_map_width);
        x2   = clip((int'(c.box_x) + int'(c.box_w) - sx) / ts, 0, sh_map_width);
        y1   = clip((int'(c.box_y) - sy) / ts, 0, sh_map_height);
        y2   = clip((int'(c.box_y) + int'(c.box_h) - sy) / ts, 0, sh_map_height);
        base = int'(c.frame_num) * sh_map_height * sh_map_width;
        for (int r = y1; r < y2; r++)
            for (int k = x1; k < x2; k++)
                if (shadow_map[(base + r * sh_map_width + k) % MAP_ENTRIES] != 0)
                    return 1'b1;
        return 1'b0;
    endfunction

    // apply one accepted command to the shadow state, queue any reply
    function automatic void predict_command(blit_cmd_t c);
        blit_reply_t r;
        case (c.cmd)
            tms_pkg::CMD_LOAD_MAP:  shadow_map[c.mem_addr % MAP_ENTRIES] = c.load_data[7:0];
            tms_pkg::CMD_LOAD_TILE: shadow_tile[c.mem_addr % TILE_WORDS] = c.load_data;
            tms_pkg::CMD_DRAW:      render_row(c);
            tms_pkg::CMD_COLLIDE:
            begin
                r.reply_kind = tms_pkg::KIND_HIT;
                r.line_word  = '0;
                r.hit_flag   = box_hits_tile(c);
                pending_replies.push_back(r);
            end
            tms_pkg::CMD_READ_LINE:
            begin
                r.reply_kind = tms_pkg::KIND_LINE;
                r.line_word  = shadow_line[c.mem_addr % LINE_WORDS];
                r.hit_flag   = 1'b0;
                pending_replies.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // reply checker
    always @(posedge clk)
    begin
        blit_reply_t want;
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply transaction with nothing pending");
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_if.reply_kind !== want.reply_kind)
                begin
                    $error("reply_kind expected %0d actual %0d", want.reply_kind,
                           rsp_if.reply_kind);
                    error_count++;
                end
                if (rsp_if.line_word !== want.line_word)
                begin
                    $error("line_word expected %h actual %h", want.line_word,
                           rsp_if.line_word);
                    error_count++;
                end
                if (rsp_if.hit_flag !== want.hit_flag)
                begin
                    $error("hit_flag expected %0d actual %0d", want.hit_flag,
                           rsp_if.hit_flag);
                    error_count++;
                end
            end
        end
    end

    // drive one command transaction; entered and left on a falling edge
    task automatic send_command(blit_cmd_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= c.cmd;
        cmd_if.mem_addr  <= c.mem_addr;
        cmd_if.load_data <= c.load_data;
        cmd_if.pos_x     <= c.pos_x;
        cmd_if.pos_y     <= c.pos_y;
        cmd_if.scan_line <= c.scan_line;
        cmd_if.frame_num <= c.frame_num;
        cmd_if.box_x     <= c.box_x;
        cmd_if.box_y     <= c.box_y;
        cmd_if.box_w     <= c.box_w;
        cmd_if.box_h     <= c.box_h;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        predict_command(c);
        @(negedge clk);
    endtask

    // frames stay inside the preloaded part of the map
    function automatic blit_cmd_t blank_command(logic [2:0] op);
        blit_cmd_t c;
        c.cmd       = op;
        c.mem_addr  = 15'($urandom);
        c.load_data = $urandom;
        c.pos_x     = 11'($urandom);
        c.pos_y     = 11'($urandom);
        c.scan_line = 10'($urandom);
        c.frame_num = 8'($urandom_range(0, frame_top));
        c.box_x     = 11'($urandom);
        c.box_y     = 11'($urandom);
        c.box_w     = 10'($urandom);
        c.box_h     = 10'($urandom);
        return c;
    endfunction

    // stop driving, then wait for every reply and the back end to settle
    task automatic settle_block();
        blit_cmd_t c;
        // a line read queues behind any draw still running
        c = blank_command(tms_pkg::CMD_READ_LINE);
        send_command(c);
        cmd_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[9:0];
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            tms_pkg::REG_MAP_WIDTH:   sh_map_width   = value & 'h7f;
            tms_pkg::REG_MAP_HEIGHT:  sh_map_height  = value & 'h7f;
            tms_pkg::REG_TILE_SIZE:   sh_tile_big    = value & 1;
            tms_pkg::REG_TRANSPARENT: sh_transparent = value & 1;
            tms_pkg::REG_VIS_WIDTH:   sh_vis_width   = value & 'h3ff;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(int mw, int mh, int big, int transp, int vw);
        settle_block();
        write_register(tms_pkg::REG_MAP_WIDTH, mw);
        write_register(tms_pkg::REG_MAP_HEIGHT, mh);
        write_register(tms_pkg::REG_TILE_SIZE, big);
        write_register(tms_pkg::REG_TRANSPARENT, transp);
        write_register(tms_pkg::REG_VIS_WIDTH, vw);
        frame_top = MAP_LOADED / (mw * mh) - 1;
        if (frame_top > 255)
            frame_top = 255;
    endtask

    // the map region and tile slots that draws and collides can reach get written
    task automatic test_memory_preload();
        blit_cmd_t c;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int a = 0; a < MAP_LOADED; a++)
        begin
            c                = blank_command(tms_pkg::CMD_LOAD_MAP);
            c.mem_addr       = 15'(a);
            c.load_data[7:0] = 8'($urandom_range(0, TOP_TILE_INDEX));
            send_command(c);
        end
        for (int a = 0; a < TILE_LOADED; a++)
        begin
            c          = blank_command(tms_pkg::CMD_LOAD_TILE);
            c.mem_addr = 15'(TILE_FIRST_WORD + a);
            case ($urandom_range(5))
                0: c.load_data = '0;
                1: c.load_data[15:0] = '0;
                2: c.load_data[31:16] = '0;
                default: ;
            endcase
            send_command(c);
        end
    endtask

    // field extremes, wrapping addresses, rows outside the sprite, unknown commands
    task automatic test_field_extremes();
        blit_cmd_t c;
        c = blank_command(tms_pkg::CMD_READ_LINE);
        c.mem_addr = 15'd0;
        send_command(c);
        c.mem_addr = 15'h7fff;
        send_command(c);
        c = blank_command(tms_pkg::CMD_LOAD_MAP);
        c.mem_addr  = 15'h7fff;
        c.load_data = 32'hffff_ffff;
        send_command(c);
        c = blank_command(tms_pkg::CMD_LOAD_TILE);
        c.mem_addr  = 15'h7fff;
        c.load_data = 32'hffff_ffff;
        send_command(c);
        c.mem_addr  = 15'd0;
        c.load_data = 32'd0;
        send_command(c);
        // draws at the corners of the position range
        c = blank_command(tms_pkg::CMD_DRAW);
        c.pos_x = -11'sd1024; c.pos_y = -11'sd1024; c.scan_line = 10'd0; c.frame_num = 8'd0;
        send_command(c);
        c.pos_x = 11'sd1023; c.pos_y = 11'sd1023; c.scan_line = 10'd1023; c.frame_num = 8'd255;
        send_command(c);
        c.pos_x = -11'sd3; c.pos_y = 11'sd0; c.scan_line = 10'd5;
        send_command(c);
        c.pos_x = 11'sd1; c.pos_y = 11'sd10; c.scan_line = 10'd3;
        send_command(c);
        // collides at the extremes of the box
        c = blank_command(tms_pkg::CMD_COLLIDE);
        c.pos_x = 11'sd0; c.pos_y = 11'sd0; c.box_x = 11'sd0; c.box_y = 11'sd0;
        c.box_w = 10'd1023; c.box_h = 10'd1023;
        send_command(c);
        c.box_w = 10'd0; c.box_h = 10'd0;
        send_command(c);
        c.pos_x = 11'sd1023; c.pos_y = 11'sd1023;
        c.box_x = -11'sd1024; c.box_y = -11'sd1024;
        send_command(c);
        c.pos_x = -11'sd1024; c.pos_y = -11'sd1024;
        c.box_x = 11'sd1023; c.box_y = 11'sd1023; c.box_w = 10'd1023; c.box_h = 10'd1023;
        send_command(c);
        for (int k = 5; k < 8; k++)
        begin
            c = blank_command(k[2:0]);
            send_command(c);
        end
        for (int w = 0; w < 8; w++)
        begin
            c = blank_command(tms_pkg::CMD_READ_LINE);
            c.mem_addr = 15'(w);
            send_command(c);
        end
    endtask

    // mostly rows that hit the sprite and boxes near it, with some noise
    function automatic blit_cmd_t random_command();
        blit_cmd_t c;
        int ts;
        int roll;
        int v;
        ts   = sh_tile_big ? 16 : 8;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            c = blank_command(tms_pkg::CMD_LOAD_MAP);
            c.load_data[7:0] = 8'($urandom_range(0, TOP_TILE_INDEX));
        end
        else if (roll < 18)
            c = blank_command(tms_pkg::CMD_LOAD_TILE);
        else if (roll < 55)
        begin
            c = blank_command(tms_pkg::CMD_DRAW);
            if ($urandom_range(9) != 0)
            begin
                v = int'(c.scan_line) - $urandom_range(0, ts * sh_map_height + 3);
                c.pos_y = 11'(v);
                v = $urandom_range(0, ts * sh_map_width + sh_vis_width + 40)
                    - ts * sh_map_width - 20;
                c.pos_x = 11'(v);
            end
        end
        else if (roll < 70)
        begin
            c = blank_command(tms_pkg::CMD_COLLIDE);
            if ($urandom_range(9) != 0)
            begin
                v = int'(c.pos_x) + $urandom_range(0, ts * sh_map_width + 40) - 40;
                c.box_x = 11'(v);
                v = int'(c.pos_y) + $urandom_range(0, ts * sh_map_height + 40) - 40;
                c.box_y = 11'(v);
                c.box_w = 10'($urandom_range(0, 63));
                c.box_h = 10'($urandom_range(0, 63));
            end
        end
        else if (roll < 96)
        begin
            c = blank_command(tms_pkg::CMD_READ_LINE);
            if ($urandom_range(7) != 0)
                c.mem_addr = 15'($urandom_range(0, LINE_WORDS - 1));
        end
        else
            c = blank_command(3'($urandom_range(5, 7)));
        return c;
    endfunction

    // six register settings, two per idling pattern
    task automatic test_random_traffic();
        int mw[6]     = '{1, 64, 8, 5, 64, 3};
        int mh[6]     = '{1, 4, 4, 3, 2, 64};
        int big[6]    = '{0, 1, 1, 0, 0, 1};
        int transp[6] = '{0, 1, 0, 1, 0, 1};
        int vw[6]     = '{2, 992, 640, 100, 992, 320};
        for (int s = 0; s < 6; s++)
        begin
            apply_setting(mw[s], mh[s], big[s], transp[s], vw[s]);
            src_idle_pct  = (s < 2) ? 6 : (s < 4) ? 81 : 0;
            sink_idle_pct = (s < 2) ? 81 : (s < 4) ? 6 : 0;
            if (s == 0)
                test_field_extremes();
            repeat (120)
                send_command(random_command());
        end
    endtask

    initial
    begin
        error_count   = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sh_map_width   = 1;
        sh_map_height  = 1;
        sh_tile_big    = 1;
        sh_transparent = 1;
        sh_vis_width   = 640;
        frame_top      = 255;
        for (int w = 0; w < LINE_WORDS; w++)
            shadow_line[w] = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = tms_pkg::CMD_LOAD_MAP;
        cmd_if.mem_addr  = '0;
        cmd_if.load_data = '0;
        cmd_if.pos_x     = '0;
        cmd_if.pos_y     = '0;
        cmd_if.scan_line = '0;
        cmd_if.frame_num = '0;
        cmd_if.box_x     = '0;
        cmd_if.box_y     = '0;
        cmd_if.box_w     = '0;
        cmd_if.box_h     = '0;
        rsp_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = tms_pkg::REG_MAP_WIDTH;
        cfg_if.data      = '0;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_memory_preload();
        test_random_traffic();
        settle_block();
        repeat (50) @(negedge clk);

        if (error_count == 0 && pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
